### rtl/ccs_pkg.sv
// ============================================================================
// ccs_pkg
// Shared types and character codes for the C comment stripper.
// ============================================================================
package ccs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // Most results that one input beat can cause.
    localparam int unsigned MaxResults = 3;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_marker;
        logic       run_last;
    } out_beat_t;

    // Results of one input beat, in delivery order, and how many are valid.
    typedef struct packed {
        out_beat_t [MaxResults-1:0] beat;
        logic [1:0]                 count;
    } res_set_t;

endpackage

### rtl/ccs_scanner.sv
// ============================================================================
// ccs_scanner
// Scan state and the per-byte decision logic; yields the results of one beat.
// ============================================================================
module ccs_scanner
    import ccs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  in_beat_t beat,
    output res_set_t res
);

    scan_mode_t mode_reg, mode_next;
    logic       quote_reg, quote_next;
    logic       slash_reg, slash_next;
    logic       star_reg, star_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            quote_reg <= 1'b0;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end
        else if (load)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
        end
    end

    always_comb
    begin
        logic [7:0] b;
        logic       last;
        logic       pre_slash;
        logic       text_path;
        logic       emit_byte;
        logic       post_slash;
        logic [1:0] cnt;

        b          = beat.in_byte;
        last       = beat.text_last;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        pre_slash  = 1'b0;
        text_path  = 1'b0;
        emit_byte  = 1'b0;

        case (mode_reg)
            MODE_LINE:
            begin
                if (b == CH_NL)
                begin
                    mode_next = MODE_TEXT;
                    emit_byte = 1'b1;
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && b == CH_SLASH)
                begin
                    mode_next = MODE_TEXT;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (b == CH_STAR);
                end
            end
            default:
            begin
                if (slash_reg)
                begin
                    slash_next = 1'b0;
                    if (b == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (b == CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        pre_slash = 1'b1;
                        text_path = 1'b1;
                    end
                end
                else
                begin
                    text_path = 1'b1;
                end
            end
        endcase

        // Ordinary text byte: quotes toggle the parity, an unquoted slash
        // is held unless nothing can follow it.
        if (text_path)
        begin
            if (b == CH_QUOTE)
            begin
                quote_next = ~quote_reg;
                emit_byte  = 1'b1;
            end
            else if (!quote_reg && b == CH_SLASH && !last)
            begin
                slash_next = 1'b1;
            end
            else
            begin
                emit_byte = 1'b1;
            end
        end

        post_slash = last && slash_next;

        res = '0;
        cnt = 2'd0;
        if (pre_slash)
        begin
            res.beat[cnt] = '{out_byte: CH_SLASH, end_marker: 1'b0, run_last: 1'b0};
            cnt = cnt + 2'd1;
        end
        if (emit_byte)
        begin
            res.beat[cnt] = '{out_byte: b, end_marker: 1'b0, run_last: 1'b0};
            cnt = cnt + 2'd1;
        end
        if (post_slash)
        begin
            res.beat[cnt] = '{out_byte: CH_SLASH, end_marker: 1'b0, run_last: 1'b0};
            cnt = cnt + 2'd1;
        end
        if (last)
        begin
            res.beat[cnt] = '{out_byte: CH_NONE, end_marker: 1'b1, run_last: 1'b0};
            cnt = cnt + 2'd1;
            mode_next  = MODE_TEXT;
            quote_next = 1'b0;
            slash_next = 1'b0;
            star_next  = 1'b0;
        end
        if (cnt != 2'd0)
        begin
            res.beat[cnt - 2'd1].run_last = 1'b1;
        end
        res.count = cnt;
    end

endmodule

### rtl/ccs_result_buf.sv
// ============================================================================
// ccs_result_buf
// Result register: holds the results of one beat and hands them out in order.
// ============================================================================
module ccs_result_buf
    import ccs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_set_t  res,
    output logic      room,
    output logic      dst_valid,
    input  logic      dst_ready,
    output out_beat_t dst_data
);

    out_beat_t [MaxResults-1:0] beat_reg;
    logic [1:0]                 rem_reg, rem_next;
    logic [1:0]                 idx_reg, idx_next;
    logic                       take;

    assign dst_valid = (rem_reg != 2'd0);
    assign dst_data  = beat_reg[idx_reg];
    assign take      = dst_valid && dst_ready;
    // A new set may enter once the last held result leaves this cycle.
    assign room      = (rem_reg == 2'd0) || (rem_reg == 2'd1 && dst_ready);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = res.count;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= res.beat;
        end
    end

    a_span_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, idx_reg} + {1'b0, rem_reg}) <= 3'(MaxResults))
        else $error("result index runs past the held set");

    a_run_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_data.run_last == (rem_reg == 2'd1)))
        else $error("run_last not on the final result of a beat");

    a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_data.end_marker) |-> dst_data.run_last)
        else $error("end marker is not the final result of its beat");

endmodule

### rtl/c_comment_stripper.sv
// ============================================================================
// c_comment_stripper
// Streaming removal of line and block comments from C source text.
// ============================================================================
// The text channel (text_valid, text_ready, text_data) takes one source byte
// per beat with a flag on the final byte of a text. The strip channel
// (strip_valid, strip_ready, strip_data) returns the kept bytes, then an end
// marker beat for each text; run_last flags the last result of each input.
//
// Each input beat is decoded in the cycle it is accepted, and its zero to
// three results land in a result register, so the first result is shown in
// the cycle after acceptance. Results leave one per cycle while strip_ready
// is high. A beat with at most one result lets the next byte in on the very
// next cycle, if its result is taken, giving one byte per cycle; a beat with
// two or three results holds off text_ready while the result register drains.
//
// Reset clears the scan state (normal text, even quote parity, nothing held)
// and empties the result register. When the receiver stalls, the shown
// result holds steady and text_ready falls once the result register cannot
// be emptied in the current cycle; no beat is lost or repeated.
// ============================================================================
module c_comment_stripper
    import ccs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_ready,
    input  in_beat_t  text_data,
    output logic      strip_valid,
    input  logic      strip_ready,
    output out_beat_t strip_data
);

    logic     room;
    logic     load;
    res_set_t res;

    // An input beat is taken whenever the result register can accept its set.
    assign text_ready = room;
    assign load       = text_valid && room;

    // Comment and quote tracking; decodes the accepted byte into results.
    ccs_scanner u_scanner (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .beat  (text_data),
        .res   (res)
    );

    // Holds the decoded results and streams them out one per cycle while strip_ready is high.
    ccs_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .room      (room),
        .dst_valid (strip_valid),
        .dst_ready (strip_ready),
        .dst_data  (strip_data)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking regression for the C comment stripper.
// ============================================================================
// A short directed table walks the comment openers and closers, quoted
// slashes and the end-of-text cases. A random run of short texts follows,
// rich in slashes, stars, quotes and newlines, with some loose noise beats.
// Every accepted text beat is run through a local copy of the scan state.
// The kept bytes and end markers it produces are queued and compared with
// the strip channel in order. Both channels idle at random.
// ============================================================================
module tb_top;
    import ccs_pkg::*;

    localparam int unsigned RandomBeats  = 180;
    localparam int unsigned StallMax     = 14;
    localparam int unsigned WatchdogMax  = 2000;
    localparam int unsigned DrainCycles  = 20;
    localparam int unsigned ReportMax    = 10;

    // One row of the directed table. Where typed is set, the expected kept
    // bytes (first one in the low byte) and the end marker are given here
    // instead of coming from the scan model.
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [1:0]  n_kept;
        logic [23:0] kept;
        logic        ends;
    } strip_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_ready;
    in_beat_t  text_data = '0;
    logic      strip_valid;
    logic      strip_ready = 1'b0;
    out_beat_t strip_data;

    // Scan state of the model, mirrored from the block's behavior.
    scan_mode_t scan_mode;
    logic       quote_odd;
    logic       slash_held;
    logic       star_held;

    out_beat_t  scan_out[$];        // results of the beat being modeled
    out_beat_t  pending_strip[$];   // results still owed by the block

    int unsigned mismatches  = 0;
    int unsigned live_beats  = 0;
    int unsigned quiet_count = 0;
    logic        send_calm   = 1'b0;
    logic        recv_calm   = 1'b0;

    strip_row_t dir_rows [0:24] = '{
        // Plain bytes, including the highest byte value and 8'h01.
        '{"a",      1'b0, 1'b1, 2'd1, {16'h0, "a"},     1'b0},
        '{8'hFF,    1'b0, 1'b1, 2'd1, {16'h0, 8'hFF},   1'b0},
        '{8'h01,    1'b0, 1'b1, 2'd1, {16'h0, 8'h01},   1'b0},
        // Line comment, closed by a newline that is kept.
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{"x",      1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_NL,    1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        // Block comment with a run of stars before the closing slash.
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_STAR,  1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_STAR,  1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_STAR,  1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        // Held slash followed by an ordinary byte.
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{"q",      1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        // Slashes inside a quoted string pass through.
        '{CH_QUOTE, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_QUOTE, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        // A slash on the final byte is kept, then the end marker.
        '{CH_SLASH, 1'b1, 1'b1, 2'd1, {16'h0, CH_SLASH}, 1'b1},
        // Held slash, then a final ordinary byte: three results.
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{"z",      1'b1, 1'b1, 2'd2, {8'h0, "z", CH_SLASH}, 1'b1},
        // Block comment left open at the end: end marker only.
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{CH_STAR,  1'b0, 1'b0, 2'd0, 24'h0,            1'b0},
        '{"c",      1'b1, 1'b1, 2'd0, 24'h0,            1'b1},
        // A text of one quote.
        '{CH_QUOTE, 1'b1, 1'b1, 2'd1, {16'h0, CH_QUOTE}, 1'b1}
    };

    c_comment_stripper u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_data   (text_data),
        .strip_valid (strip_valid),
        .strip_ready (strip_ready),
        .strip_data  (strip_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------------
    function automatic void scan_clear();
        scan_mode  = MODE_TEXT;
        quote_odd  = 1'b0;
        slash_held = 1'b0;
        star_held  = 1'b0;
    endfunction

    function automatic void keep_byte(input logic [7:0] ch, input logic endm);
        out_beat_t r;
        r.out_byte   = ch;
        r.end_marker = endm;
        r.run_last   = 1'b0;
        scan_out.push_back(r);
    endfunction

    // Ordinary text with no slash held. A quote toggles the parity; outside
    // quotes a slash is held back unless it is the last byte of the text.
    function automatic void scan_text(input logic [7:0] ch, input logic last);
        if (ch == CH_QUOTE)
        begin
            quote_odd = ~quote_odd;
            keep_byte(ch, 1'b0);
        end
        else if (!quote_odd && ch == CH_SLASH && !last)
        begin
            slash_held = 1'b1;
        end
        else
        begin
            keep_byte(ch, 1'b0);
        end
    endfunction

    // Work out the results of one text beat into scan_out.
    function automatic void scan_beat(input in_beat_t b);
        logic [7:0] ch;
        logic       last;
        ch   = b.in_byte;
        last = b.text_last;
        scan_out.delete();
        case (scan_mode)
            MODE_LINE:
            begin
                if (ch == CH_NL)
                begin
                    scan_mode = MODE_TEXT;
                    keep_byte(ch, 1'b0);
                end
            end
            MODE_BLOCK:
            begin
                if (star_held && ch == CH_SLASH)
                begin
                    scan_mode = MODE_TEXT;
                    star_held = 1'b0;
                end
                else
                begin
                    star_held = (ch == CH_STAR);
                end
            end
            default:
            begin
                if (slash_held)
                begin
                    slash_held = 1'b0;
                    if (ch == CH_SLASH)
                    begin
                        scan_mode = MODE_LINE;
                    end
                    else if (ch == CH_STAR)
                    begin
                        scan_mode = MODE_BLOCK;
                        star_held = 1'b0;
                    end
                    else
                    begin
                        keep_byte(CH_SLASH, 1'b0);
                        scan_text(ch, last);
                    end
                end
                else
                begin
                    scan_text(ch, last);
                end
            end
        endcase
        if (last)
        begin
            if (slash_held)
            begin
                keep_byte(CH_SLASH, 1'b0);
            end
            keep_byte(CH_NONE, 1'b1);
            scan_clear();
        end
        if (scan_out.size() != 0)
        begin
            scan_out[scan_out.size() - 1].run_last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Text channel: one beat, after a random gap, held until accepted
    // ------------------------------------------------------------------------
    task automatic send_text(input in_beat_t b, input strip_row_t row);
        int unsigned gap;
        out_beat_t   r;
        gap = send_calm ? 0 : $urandom_range(0, StallMax);
        // Valid only drops when a gap follows, so it is never lowered and
        // raised again within one time step.
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_data  <= b;
        do
            @(posedge clk);
        while (!text_ready);

        // The beat went in at this edge; log what it must produce.
        scan_beat(b);
        live_beats++;
        if (row.typed)
        begin
            scan_out.delete();
            for (int k = 0; k < row.n_kept; k++)
            begin
                keep_byte(row.kept[8*k +: 8], 1'b0);
            end
            if (row.ends)
            begin
                keep_byte(CH_NONE, 1'b1);
            end
            r = scan_out.pop_back();
            r.run_last = 1'b1;
            scan_out.push_back(r);
        end
        foreach (scan_out[k])
        begin
            pending_strip.push_back(scan_out[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Strip channel: ready drops for a random stall before each result
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                recv_calm = ~recv_calm;
            end
            stall = recv_calm ? 0 : $urandom_range(0, StallMax);
            if (stall > 0)
            begin
                strip_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            strip_ready <= 1'b1;
            do
                @(posedge clk);
            while (!strip_valid);
        end
    end

    // Compare each accepted result with the oldest one still owed.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && strip_valid && strip_ready)
        begin
            if (pending_strip.size() == 0)
            begin
                mismatches++;
                if (mismatches <= ReportMax)
                begin
                    $display("%0t: unexpected result byte %h end %b last %b", $realtime,
                             strip_data.out_byte, strip_data.end_marker,
                             strip_data.run_last);
                end
            end
            else
            begin
                want = pending_strip.pop_front();
                if (strip_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= ReportMax)
                    begin
                        $display("%0t: expected byte %h end %b last %b, got %h %b %b",
                                 $realtime, want.out_byte, want.end_marker,
                                 want.run_last, strip_data.out_byte,
                                 strip_data.end_marker, strip_data.run_last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((text_valid && text_ready) || (strip_valid && strip_ready))
        begin
            quiet_count <= 0;
        end
        else if (rst_n)
        begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= WatchdogMax)
            begin
                $display("c_comment_stripper regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        in_beat_t    b;
        strip_row_t  row;
        int unsigned len;

        scan_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            b.in_byte   = dir_rows[i].ch;
            b.text_last = dir_rows[i].last;
            send_text(b, dir_rows[i]);
        end

        // Random texts. Most are whole texts heavy in comment and quote
        // characters; the rest are loose bytes that may end a text anywhere.
        row = '0;
        live_beats = 0;
        while (live_beats < RandomBeats)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                b.in_byte   = 8'($urandom_range(1, 255));
                b.text_last = ($urandom_range(0, 7) == 0);
                send_text(b, row);
            end
            else
            begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++)
                begin
                    case ($urandom_range(0, 11))
                        0, 1, 2: b.in_byte = CH_SLASH;
                        3, 4:    b.in_byte = CH_STAR;
                        5:       b.in_byte = CH_QUOTE;
                        6:       b.in_byte = CH_NL;
                        7, 8:    b.in_byte = 8'h61 + 8'($urandom_range(0, 25));
                        default: b.in_byte = 8'($urandom_range(1, 255));
                    endcase
                    b.text_last = (k == len - 1);
                    send_text(b, row);
                end
            end
        end
        text_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (pending_strip.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0 && pending_strip.size() == 0)
        begin
            $display("c_comment_stripper regression: pass");
        end
        else
        begin
            $display("c_comment_stripper regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/ccs_pkg.sv
rtl/ccs_scanner.sv
rtl/ccs_result_buf.sv
rtl/c_comment_stripper.sv
test/tb_top.sv
